// ===== rtl/core/control_surface_slew_limiter_defines.svh =====
// ----------------------------------------------------------------------------
// control_surface_slew_limiter_defines
// Assertion macros for the slew limiter; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CONTROL_SURFACE_SLEW_LIMITER_DEFINES_SVH
`define CONTROL_SURFACE_SLEW_LIMITER_DEFINES_SVH

`ifndef SYNTH
// checked outside reset
`define CSL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define CSL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSL_ASSERT(name, prop, msg)
`define CSL_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/core/csl_pkg.sv =====
// ----------------------------------------------------------------------------
// csl_pkg
// Widths, register indexes and stage types for the control surface slew limiter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csl_pkg;

    localparam int CMD_W      = 16;
    localparam int LIMIT_W    = 15;
    localparam int SLEW_W     = 13;
    localparam int TICK_W     = 8;
    localparam int ANGLE_W    = 16;
    localparam int THR_W      = 15;
    localparam int STEP_W     = SLEW_W + TICK_W;
    localparam int FRAC_SHIFT = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;
    localparam int IN_W       = 4 * CMD_W + TICK_W;
    localparam int OUT_W      = 64;

    localparam logic signed [CMD_W-1:0] CMD_MAX = 16'sh7FFF;
    localparam logic signed [CMD_W-1:0] CMD_MIN = 16'sh8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ELEV_UP   = 3'd0,
        REG_ELEV_DOWN = 3'd1,
        REG_AILERON   = 3'd2,
        REG_RUDDER    = 3'd3,
        REG_SLEW      = 3'd4
    } cfg_reg_t;

    // one item after target scaling, ahead of the position update
    typedef struct packed {
        logic signed [ANGLE_W-1:0] elev_tgt;
        logic signed [ANGLE_W-1:0] ail_tgt;
        logic signed [ANGLE_W-1:0] rud_tgt;
        logic [STEP_W-1:0]         step;
        logic [THR_W-1:0]          thr;
        logic                      upd;
    } move_t;

endpackage

// ===== rtl/core/control_surface_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// control_surface_slew_limiter
// Stages from input beat to result beat: input reg, target reg,
//   position/result reg; the multipliers sit in the middle stage.
// Throughput: one beat per cycle unless m_axis_tready stalls the output; positions feed back into their own update.
// Reset: limits, slew rate, positions and throttle clear to zero; no beats held.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "control_surface_slew_limiter_defines.svh"

module control_surface_slew_limiter
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csl_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [csl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pitch_command, roll_command, yaw_command, throttle_command, elapsed_ticks
    input  logic [csl_pkg::IN_W-1:0]            s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // elevator_angle, aileron_angle, rudder_angle, throttle_level, pad bit
    output logic [csl_pkg::OUT_W-1:0]           m_axis_tdata,
    // updated
    output logic [0:0]                          m_axis_tuser
);

    // configuration
    logic [csl_pkg::LIMIT_W-1:0] elev_up_reg;
    logic [csl_pkg::LIMIT_W-1:0] elev_down_reg;
    logic [csl_pkg::LIMIT_W-1:0] ail_limit_reg;
    logic [csl_pkg::LIMIT_W-1:0] rud_limit_reg;
    logic [csl_pkg::SLEW_W-1:0]  slew_reg;

    // pipeline
    logic                        in_valid_reg;
    logic [csl_pkg::IN_W-1:0]    in_data_reg;
    logic                        mv_valid_reg;
    csl_pkg::move_t              mv_reg;
    csl_pkg::move_t              mv_next;
    logic                        out_valid_reg;
    logic                        upd_reg;
    logic                        ld3;
    logic                        en2;
    logic                        en1;

    // state
    logic signed [csl_pkg::ANGLE_W-1:0] elev_pos_reg;
    logic signed [csl_pkg::ANGLE_W-1:0] ail_pos_reg;
    logic signed [csl_pkg::ANGLE_W-1:0] rud_pos_reg;
    logic [csl_pkg::THR_W-1:0]          thr_pos_reg;
    logic signed [csl_pkg::ANGLE_W-1:0] elev_pos_next;
    logic signed [csl_pkg::ANGLE_W-1:0] ail_pos_next;
    logic signed [csl_pkg::ANGLE_W-1:0] rud_pos_next;

    // input fields
    logic signed [csl_pkg::CMD_W-1:0]   pitch_cmd;
    logic signed [csl_pkg::CMD_W-1:0]   roll_cmd;
    logic signed [csl_pkg::CMD_W-1:0]   yaw_cmd;
    logic signed [csl_pkg::CMD_W-1:0]   thr_cmd;
    logic [csl_pkg::TICK_W-1:0]         ticks;
    logic [csl_pkg::LIMIT_W-1:0]        elev_limit;

    // scaled targets
    logic signed [csl_pkg::ANGLE_W-1:0] elev_tgt;
    logic signed [csl_pkg::ANGLE_W-1:0] ail_tgt;
    logic signed [csl_pkg::ANGLE_W-1:0] rud_tgt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elev_up_reg   <= '0;
            elev_down_reg <= '0;
            ail_limit_reg <= '0;
            rud_limit_reg <= '0;
            slew_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                csl_pkg::REG_ELEV_UP:   elev_up_reg   <= cfg_wdata;
                csl_pkg::REG_ELEV_DOWN: elev_down_reg <= cfg_wdata;
                csl_pkg::REG_AILERON:   ail_limit_reg <= cfg_wdata;
                csl_pkg::REG_RUDDER:    rud_limit_reg <= cfg_wdata;
                csl_pkg::REG_SLEW:      slew_reg      <= cfg_wdata[csl_pkg::SLEW_W-1:0];
                default: ;
            endcase
        end
    end

    // stall only propagates back through full stages
    assign ld3           = !out_valid_reg || m_axis_tready;
    assign en2           = !mv_valid_reg || ld3;
    assign en1           = !in_valid_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en1)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
    end

    assign pitch_cmd = in_data_reg[0 +: csl_pkg::CMD_W];
    assign roll_cmd  = in_data_reg[csl_pkg::CMD_W +: csl_pkg::CMD_W];
    assign yaw_cmd   = in_data_reg[2*csl_pkg::CMD_W +: csl_pkg::CMD_W];
    assign thr_cmd   = in_data_reg[3*csl_pkg::CMD_W +: csl_pkg::CMD_W];
    assign ticks     = in_data_reg[4*csl_pkg::CMD_W +: csl_pkg::TICK_W];

    // a clamped command keeps its sign, so the raw sign bit picks the limit
    assign elev_limit = pitch_cmd[csl_pkg::CMD_W-1] ? elev_down_reg : elev_up_reg;

    csl_scale u_scale_elev
    (
        .cmd    (pitch_cmd),
        .limit  (elev_limit),
        .target (elev_tgt)
    );

    csl_scale u_scale_ail
    (
        .cmd    (roll_cmd),
        .limit  (ail_limit_reg),
        .target (ail_tgt)
    );

    csl_scale u_scale_rud
    (
        .cmd    (yaw_cmd),
        .limit  (rud_limit_reg),
        .target (rud_tgt)
    );

    always_comb
    begin
        mv_next.elev_tgt = elev_tgt;
        mv_next.ail_tgt  = ail_tgt;
        mv_next.rud_tgt  = rud_tgt;
        mv_next.step     = csl_pkg::STEP_W'(slew_reg) * csl_pkg::STEP_W'(ticks);
        mv_next.thr      = thr_cmd[csl_pkg::CMD_W-1] ? '0 : thr_cmd[csl_pkg::THR_W-1:0];
        mv_next.upd      = (ticks != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_valid_reg <= 1'b0;
        end
        else if (en2)
        begin
            mv_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && in_valid_reg)
        begin
            mv_reg <= mv_next;
        end
    end

    csl_slew u_slew_elev
    (
        .cur      (elev_pos_reg),
        .target   (mv_reg.elev_tgt),
        .step     (mv_reg.step),
        .pos_next (elev_pos_next)
    );

    csl_slew u_slew_ail
    (
        .cur      (ail_pos_reg),
        .target   (mv_reg.ail_tgt),
        .step     (mv_reg.step),
        .pos_next (ail_pos_next)
    );

    csl_slew u_slew_rud
    (
        .cur      (rud_pos_reg),
        .target   (mv_reg.rud_tgt),
        .step     (mv_reg.step),
        .pos_next (rud_pos_next)
    );

    // positions double as the result register: they change only when a new
    // beat enters the output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            upd_reg       <= 1'b0;
            elev_pos_reg  <= '0;
            ail_pos_reg   <= '0;
            rud_pos_reg   <= '0;
            thr_pos_reg   <= '0;
        end
        else if (ld3)
        begin
            out_valid_reg <= mv_valid_reg;
            if (mv_valid_reg)
            begin
                upd_reg <= mv_reg.upd;
                if (mv_reg.upd)
                begin
                    elev_pos_reg <= elev_pos_next;
                    ail_pos_reg  <= ail_pos_next;
                    rud_pos_reg  <= rud_pos_next;
                    thr_pos_reg  <= mv_reg.thr;
                end
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, thr_pos_reg, rud_pos_reg, ail_pos_reg, elev_pos_reg};
    assign m_axis_tuser  = upd_reg;

    `CSL_ASSERT(a_zero_ticks_hold, (mv_valid_reg && ld3 && !mv_reg.upd) |=> ($stable(elev_pos_reg) && $stable(ail_pos_reg) && $stable(rud_pos_reg) && $stable(thr_pos_reg)), "state moved on a zero-tick beat")
    `CSL_ASSERT(a_state_only_on_load, !(mv_valid_reg && ld3) |=> ($stable(elev_pos_reg) && $stable(ail_pos_reg) && $stable(rud_pos_reg) && $stable(thr_pos_reg)), "state moved with no beat entering output stage")
    `CSL_ASSERT(a_upd_follows_stage, (mv_valid_reg && ld3) |=> (upd_reg == $past(mv_reg.upd)), "updated flag does not match its beat")
    `CSL_ASSERT_ALWAYS(a_ready_when_room, !s_axis_tready |-> (in_valid_reg && mv_valid_reg && out_valid_reg), "input stalled with an empty stage")

endmodule

// ===== rtl/core/csl_scale.sv =====
// ----------------------------------------------------------------------------
// csl_scale
// Command times deflection limit, floor-shifted to a Q2.13 target angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csl_scale
(
    input  logic signed [csl_pkg::CMD_W-1:0]   cmd,
    input  logic        [csl_pkg::LIMIT_W-1:0] limit,
    output logic signed [csl_pkg::ANGLE_W-1:0] target
);

    logic signed [csl_pkg::CMD_W-1:0]                   cmd_c;
    logic signed [csl_pkg::CMD_W+csl_pkg::LIMIT_W-1:0]  prod;

    always_comb
    begin
        cmd_c = (cmd == csl_pkg::CMD_MIN) ? -csl_pkg::CMD_MAX : cmd;
        prod  = cmd_c * $signed({1'b0, limit});
    end

    // part-select of the signed product is a floor shift
    assign target = prod[csl_pkg::FRAC_SHIFT +: csl_pkg::ANGLE_W];

endmodule

// ===== rtl/core/csl_slew.sv =====
// ----------------------------------------------------------------------------
// csl_slew
// Moves one stored angle toward its target by at most the step size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csl_slew
(
    input  logic signed [csl_pkg::ANGLE_W-1:0] cur,
    input  logic signed [csl_pkg::ANGLE_W-1:0] target,
    input  logic        [csl_pkg::STEP_W-1:0]  step,
    output logic signed [csl_pkg::ANGLE_W-1:0] pos_next
);

    localparam int W = csl_pkg::STEP_W + 1;

    logic signed [csl_pkg::ANGLE_W:0] diff;
    logic signed [W-1:0]              diff_w;
    logic signed [W-1:0]              step_w;
    logic signed [W-1:0]              cur_w;
    logic signed [W-1:0]              move;
    logic signed [W-1:0]              sum;

    always_comb
    begin
        diff   = {target[csl_pkg::ANGLE_W-1], target} - {cur[csl_pkg::ANGLE_W-1], cur};
        diff_w = {{(W-csl_pkg::ANGLE_W-1){diff[csl_pkg::ANGLE_W]}}, diff};
        step_w = {1'b0, step};
        cur_w  = {{(W-csl_pkg::ANGLE_W){cur[csl_pkg::ANGLE_W-1]}}, cur};
        if (diff_w > step_w)
        begin
            move = step_w;
        end
        else if (diff_w < -step_w)
        begin
            move = -step_w;
        end
        else
        begin
            move = diff_w;
        end
        sum      = cur_w + move;
        // result lies between cur and target, so it fits
        pos_next = sum[csl_pkg::ANGLE_W-1:0];
    end

endmodule
